@@ src/fba_pkg.sv @@
// ============================================================================
// fba_pkg: shared types and constants of the frame bitmap allocator
// Item layouts, status codes, request codes and sequencer states.
// ============================================================================
package fba_pkg;

    // Fixed field widths
    localparam int FRAME_W  = 14;
    localparam int LIMIT_W  = 15;

    // Frame limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    // Request codes
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_NOTHING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // Request item
    typedef struct packed {
        req_type_t            req_type;
        logic [FRAME_W-1:0]   current_frame;
        logic                 kernel_only;
        logic                 writable;
    } req_t;

    // Result item
    typedef struct packed {
        logic [FRAME_W-1:0]   frame_number;
        logic                 present_bit;
        logic                 rw_bit;
        logic                 user_bit;
        status_t              status;
    } rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_SCAN    = 3'd2,
        ST_FREE_WR = 3'd3,
        ST_RESP    = 3'd4
    } state_t;

endpackage

@@ src/fba_req_if.sv @@
// ============================================================================
// fba_req_if: request channel
// Valid/ready channel carrying one allocate or free request item.
// ============================================================================
interface fba_req_if;
    logic          valid;
    logic          ready;
    fba_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/fba_rsp_if.sv @@
// ============================================================================
// fba_rsp_if: result channel
// Valid/ready channel carrying one result item per request.
// ============================================================================
interface fba_rsp_if;
    logic          valid;
    logic          ready;
    fba_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/frame_bitmap_allocator.sv @@
// ============================================================================
// frame_bitmap_allocator: first-fit physical frame allocator
// Used/free bitmap in a word memory, scanned one word per cycle.
// ============================================================================
// One bit per frame lives in a memory of MAX_FRAMES/WORD_BITS words
// (WORD_BITS a power of two). After reset the block sweeps the memory to
// zero, one word per cycle, and accepts no item until done; frame_limit
// writes are taken at any time. Items are handled one at a time. An
// allocate reads one bitmap word per cycle through the single read port,
// starting at word 0, until it finds a word with a free frame or reaches
// the frame limit. A free is a read-modify-write of one word; requests
// that change nothing go straight to the result step. A finished result
// waits in an output register until taken.
// ============================================================================
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 16384,
    parameter int WORD_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fba_pkg::LIMIT_W-1:0]  cfg_wdata,
    fba_req_if.sink                      req,
    fba_rsp_if.source                    rsp
);

    localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam int LIM_W     = ($clog2(MAX_FRAMES + 1) > fba_pkg::LIMIT_W) ?
                               $clog2(MAX_FRAMES + 1) : fba_pkg::LIMIT_W;
    localparam int FW        = fba_pkg::FRAME_W;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    fba_pkg::state_t          state_reg, state_next;
    logic [fba_pkg::LIMIT_W-1:0] limit_reg;

    logic [WORD_BITS-1:0]     bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0]     rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [WORD_BITS-1:0]     mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;

    logic [ADDR_W-1:0]        clr_addr_reg;
    logic [ADDR_W-1:0]        scan_addr_reg;
    logic [CNT_W-1:0]         words_reg;
    logic [FW-1:0]            cur_reg;
    logic                     kernel_reg;
    logic                     write_reg;

    fba_pkg::rsp_t            res_reg, res_next;
    logic                     res_load;
    logic                     rsp_valid_reg;
    fba_pkg::rsp_t            rsp_data_reg;
    logic                     rsp_load;
    logic                     rsp_free;

    logic                     accept;
    logic                     scan_step;

    logic [LIM_W-1:0]         lim_ext;
    logic [LIM_W-1:0]         lim_sat;
    logic [CNT_W-1:0]         words_calc;
    logic [FW-1:0]            req_word;
    logic                     req_in_range;
    logic                     req_cur_zero;
    logic [CNT_W-1:0]         scan_count;

    logic                     zf_full;
    logic [WORD_BITS-1:0]     zf_onehot;
    logic [BIT_W-1:0]         zf_idx;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign accept       = req.valid && req.ready;
    assign rsp_free     = !rsp_valid_reg || rsp.ready;

    assign lim_ext      = LIM_W'(limit_reg);
    assign lim_sat      = (lim_ext > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : lim_ext;
    assign words_calc   = CNT_W'(lim_sat >> BIT_W);

    assign req_word     = req.data.current_frame >> BIT_W;
    assign req_in_range = 32'(req_word) < 32'(NUM_WORDS);
    assign req_cur_zero = (req.data.current_frame == '0);
    assign scan_count   = CNT_W'(scan_addr_reg) + CNT_W'(1);

    // ------------------------------------------------------------------
    // Lowest free frame in the word just read
    // ------------------------------------------------------------------
    fba_zero_find #(
        .W (WORD_BITS)
    ) u_zero_find (
        .word   (rd_data_reg),
        .full   (zf_full),
        .onehot (zf_onehot),
        .idx    (zf_idx)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                if (32'(clr_addr_reg) == NUM_WORDS - 1)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (!req_cur_zero && req.data.req_type == fba_pkg::REQ_FREE
                                 && req_in_range)
                    begin
                        state_next = fba_pkg::ST_FREE_WR;
                    end
                    else if (req_cur_zero && req.data.req_type == fba_pkg::REQ_ALLOC
                             && words_calc != '0)
                    begin
                        state_next = fba_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fba_pkg::ST_RESP;
                    end
                end
            end
            fba_pkg::ST_SCAN:
            begin
                if (!zf_full || scan_count >= words_reg)
                begin
                    state_next = fba_pkg::ST_RESP;
                end
            end
            fba_pkg::ST_FREE_WR:
            begin
                state_next = fba_pkg::ST_RESP;
            end
            fba_pkg::ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: memory port, handshake, result
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = scan_addr_reg;
        mem_wdata  = rd_data_reg;
        mem_raddr  = '0;
        req.ready  = 1'b0;
        rsp_load   = 1'b0;
        scan_step  = 1'b0;
        res_load   = 1'b0;
        res_next   = '0;
        res_next.status = fba_pkg::STATUS_DONE;

        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            fba_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                // free reads the frame's word, allocate starts at word 0
                if (req.data.req_type == fba_pkg::REQ_FREE)
                begin
                    mem_raddr = ADDR_W'(req_word);
                end
                res_load = accept;
                priority if (req.data.req_type == fba_pkg::REQ_ALLOC && !req_cur_zero)
                begin
                    res_next.status = fba_pkg::STATUS_NOTHING;
                end
                else if (req.data.req_type == fba_pkg::REQ_FREE && req_cur_zero)
                begin
                    res_next.status = fba_pkg::STATUS_NOTHING;
                end
                else if (req.data.req_type == fba_pkg::REQ_ALLOC && words_calc == '0)
                begin
                    res_next.status = fba_pkg::STATUS_FULL;
                end
                else
                begin
                    res_next.status = fba_pkg::STATUS_DONE;
                end
            end
            fba_pkg::ST_SCAN:
            begin
                // next word is fetched while this one is checked
                mem_raddr = ADDR_W'(scan_count);
                if (!zf_full)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = scan_addr_reg;
                    mem_wdata = rd_data_reg | zf_onehot;
                    res_load  = 1'b1;
                    res_next.frame_number = FW'({scan_addr_reg, zf_idx});
                    res_next.present_bit  = 1'b1;
                    res_next.rw_bit       = write_reg;
                    res_next.user_bit     = !kernel_reg;
                    res_next.status       = fba_pkg::STATUS_DONE;
                end
                else if (scan_count >= words_reg)
                begin
                    res_load        = 1'b1;
                    res_next.status = fba_pkg::STATUS_FULL;
                end
                else
                begin
                    scan_step = 1'b1;
                end
            end
            fba_pkg::ST_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cur_reg >> BIT_W);
                mem_wdata = rd_data_reg & ~(WORD_BITS'(1) << cur_reg[BIT_W-1:0]);
            end
            fba_pkg::ST_RESP:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bitmap memory: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fba_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            limit_reg     <= fba_pkg::LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fba_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg       <= req.data.current_frame;
            kernel_reg    <= req.data.kernel_only;
            write_reg     <= req.data.writable;
            words_reg     <= words_calc;
            scan_addr_reg <= '0;
        end
        else if (scan_step)
        begin
            scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_IDLE) |-> !mem_we)
        else $error("bitmap written while idle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != fba_pkg::ST_IDLE))
        else $error("sequencer idle right after accepting an item");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == fba_pkg::ST_RESP))
        else $error("result shown outside the response step");

    a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_SCAN) |-> (CNT_W'(scan_addr_reg) < words_reg))
        else $error("scan beyond frame limit");

    a_alloc_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::ST_SCAN && mem_we)
            |-> ($countones(mem_wdata ^ rd_data_reg) == 1))
        else $error("allocation changed other than one bit");

endmodule

@@ src/fba_zero_find.sv @@
// ============================================================================
// fba_zero_find: lowest clear bit of one bitmap word
// Isolates the lowest zero with one increment and encodes its position.
// ============================================================================
module fba_zero_find #(
    parameter int W = 32
) (
    input  logic [W-1:0]         word,
    output logic                 full,
    output logic [W-1:0]         onehot,
    output logic [$clog2(W)-1:0] idx
);

    localparam int IDX_W = $clog2(W);

    // ~x & (x + 1) keeps only the lowest zero of x
    assign full   = &word;
    assign onehot = ~word & (word + W'(1));

    // One-hot to binary: each index bit ORs the positions that have it set
    always_comb
    begin
        idx = '0;
        for (int k = 0; k < IDX_W; k++)
        begin
            for (int i = 0; i < W; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    idx[k] = idx[k] | onehot[i];
                end
            end
        end
    end

endmodule
